FILE: rtl/esc_pkg.sv
// Shared types and constants for the environmental sensor compensation pipeline.
`timescale 1ns / 1ps

package esc_pkg;

    localparam int ESC_CFG_IDX_W = 3;
    localparam int ESC_CFG_DATA_W = 64;
    localparam int ESC_DIV_BITS = 2;

    // Fixed offsets and scale factors of the compensation formulas.
    localparam logic [31:0] ESC_T_HUM_OFS = 32'd76800;
    localparam logic [33:0] ESC_T_PRS_OFS = 34'd128000;
    localparam logic [31:0] ESC_HUM_MAX = 32'd419430400;
    localparam logic [20:0] ESC_P_BASE = 21'd1048576;
    localparam logic [31:0] ESC_P_SCALE = 32'd3125;
    localparam logic [31:0] ESC_W_OFS = 32'd2097152;
    localparam logic [63:0] ESC_U_OFS = 64'h0000_8000_0000_0000;

    typedef enum logic [ESC_CFG_IDX_W-1:0] {
        REG_TEMP_COEFFS = 3'd0,
        REG_PRESS_LOW   = 3'd1,
        REG_PRESS_HIGH  = 3'd2,
        REG_PRESS_NINE  = 3'd3,
        REG_HUM_COEFFS  = 3'd4
    } esc_reg_e;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } esc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [16:0]        humidity_q22_10;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } esc_out_t;

    // Results that are already final and ride alongside the pressure path.
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        inv;
    } esc_side_t;

endpackage

FILE: rtl/env_sensor_compensation.sv
// Top level: pipelined temperature, humidity and pressure compensation.
// Throughput is one sample per cycle; the pressure divider is unrolled into
// 64/DIV_BITS pipeline stages that resolve DIV_BITS quotient bits each.
// The whole pipeline stalls together when a result is held by the consumer.
// Reset clears all valid bits and the calibration registers to zero.
`timescale 1ns / 1ps

module env_sensor_compensation
    import esc_pkg::*;
#(
    parameter int DIV_BITS = ESC_DIV_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [ESC_CFG_IDX_W-1:0]  cfg_index,
    input  logic [ESC_CFG_DATA_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  esc_in_t                   s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output esc_out_t                  m_data
);

    localparam int NDS = 64 / DIV_BITS;
    localparam int NST = NDS + 20;

    // Calibration registers.
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;
    logic [63:0] hum_coeffs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg <= '0;
            press_high_reg <= '0;
            press_nine_reg <= '0;
            hum_coeffs_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_wdata[47:0];
                REG_PRESS_LOW:   press_low_reg <= cfg_wdata;
                REG_PRESS_HIGH:  press_high_reg <= cfg_wdata;
                REG_PRESS_NINE:  press_nine_reg <= cfg_wdata[15:0];
                REG_HUM_COEFFS:  hum_coeffs_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    logic [15:0] t1, t2, t3;
    logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]  h1, h3, h6;
    logic [15:0] h2;
    logic [11:0] h4, h5;

    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = temp_coeffs_reg[31:16];
    assign t3 = temp_coeffs_reg[47:32];
    assign p1 = press_low_reg[15:0];
    assign p2 = press_low_reg[31:16];
    assign p3 = press_low_reg[47:32];
    assign p4 = press_low_reg[63:48];
    assign p5 = press_high_reg[15:0];
    assign p6 = press_high_reg[31:16];
    assign p7 = press_high_reg[47:32];
    assign p8 = press_high_reg[63:48];
    assign p9 = press_nine_reg;
    assign h1 = hum_coeffs_reg[7:0];
    assign h2 = hum_coeffs_reg[23:8];
    assign h3 = hum_coeffs_reg[31:24];
    assign h4 = hum_coeffs_reg[43:32];
    assign h5 = hum_coeffs_reg[55:44];
    assign h6 = hum_coeffs_reg[63:56];

    // Global stall: every stage moves when the output register can take data.
    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // Stage registers ahead of the divider.
    logic [31:0] a1_reg, b1_reg, m2_reg, bb2_reg, v1t3_reg, m3_reg, tf4_reg;
    logic [15:0] adch1_reg, adch2_reg, adch3_reg, adch4_reg, adch5_reg, adch6_reg;
    logic [19:0] adcp1_reg, adcp2_reg, adcp3_reg, adcp4_reg, adcp5_reg, adcp6_reg;
    logic [19:0] adcp7_reg, adcp8_reg;
    logic [31:0] temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg;
    logic [31:0] temp10_reg, temp11_reg, temp12_reg, temp13_reg;
    logic [31:0] h5_reg, hx6_reg, hy6_reg, hz6_reg;
    logic [33:0] pv5_reg;
    logic [63:0] sq6_reg;
    logic signed [49:0] v1p5_6_reg, v1p5_7_reg, v1p2_6_reg, v1p2_7_reg, v1p2_8_reg;
    logic [31:0] x7_reg, y7_reg, z7_reg, x8_reg, yz8_reg, x9_reg, wh9_reg, x10_reg, w10_reg;
    logic signed [48:0] lo6_7_reg, lo3_7_reg;
    logic [31:0] hi6_7_reg, hi3_7_reg;
    logic [63:0] v2_8_reg, v1a8_reg, u9_reg, pn9_reg;
    logic [47:0] ul10_reg;
    logic [31:0] uh10_reg, nh10_reg;
    logic [43:0] nl10_reg;
    logic [31:0] hh11_reg, hh12_reg, qq12_reg, hh13_reg, qh13_reg;
    logic [30:0] dv11_reg;
    logic [63:0] num11_reg;
    logic        neg12_reg, neg13_reg, inv12_reg, inv13_reg;
    logic [63:0] mn12_reg, mn13_reg;
    logic [30:0] md12_reg, md13_reg;
    esc_side_t   side14_reg;
    logic        neg14_reg;
    logic [63:0] mn14_reg;
    logic [30:0] md14_reg;

    logic [31:0] q12, hf14, hc14;
    logic [63:0] u_prod11;
    logic [20:0] pb9;

    assign u_prod11 = {16'b0, ul10_reg} + {uh10_reg, 32'b0};
    assign pb9 = ESC_P_BASE - {1'b0, adcp8_reg};
    assign q12 = 32'($signed(hh11_reg) >>> 15);

    always_comb begin
        hf14 = hh13_reg - 32'($signed(qh13_reg) >>> 4);
        if (hf14[31]) begin
            hc14 = '0;
        end else if (hf14 > ESC_HUM_MAX) begin
            hc14 = ESC_HUM_MAX;
        end else begin
            hc14 = hf14;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // Temperature.
            a1_reg <= 32'(s_data.raw_temperature >> 3) - {15'b0, t1, 1'b0};
            b1_reg <= 32'(s_data.raw_temperature >> 4) - {16'b0, t1};
            adch1_reg <= s_data.raw_humidity;
            adcp1_reg <= s_data.raw_pressure;

            m2_reg <= a1_reg * {{16{t2[15]}}, t2};
            bb2_reg <= b1_reg * b1_reg;
            adch2_reg <= adch1_reg;
            adcp2_reg <= adcp1_reg;

            v1t3_reg <= 32'($signed(m2_reg) >>> 11);
            m3_reg <= 32'($signed(bb2_reg) >>> 12) * {{16{t3[15]}}, t3};
            adch3_reg <= adch2_reg;
            adcp3_reg <= adcp2_reg;

            tf4_reg <= v1t3_reg + 32'($signed(m3_reg) >>> 14);
            adch4_reg <= adch3_reg;
            adcp4_reg <= adcp3_reg;

            temp5_reg <= 32'($signed({tf4_reg[29:0], 2'b0} + tf4_reg + 32'd128) >>> 8);
            h5_reg <= tf4_reg - ESC_T_HUM_OFS;
            pv5_reg <= {{2{tf4_reg[31]}}, tf4_reg} - ESC_T_PRS_OFS;
            adch5_reg <= adch4_reg;
            adcp5_reg <= adcp4_reg;

            // Humidity and pressure split here.
            temp6_reg <= temp5_reg;
            hx6_reg <= h5_reg * {{20{h5[11]}}, h5};
            hy6_reg <= h5_reg * {{24{h6[7]}}, h6};
            hz6_reg <= h5_reg * {24'b0, h3};
            sq6_reg <= 64'($signed(pv5_reg) * $signed(pv5_reg));
            v1p5_6_reg <= $signed(pv5_reg) * $signed(p5);
            v1p2_6_reg <= $signed(pv5_reg) * $signed(p2);
            adch6_reg <= adch5_reg;
            adcp6_reg <= adcp5_reg;

            temp7_reg <= temp6_reg;
            x7_reg <= 32'($signed({2'b0, adch6_reg, 14'b0} - {h4, 20'b0} - hx6_reg
                                  + 32'd16384) >>> 15);
            y7_reg <= 32'($signed(hy6_reg) >>> 10);
            z7_reg <= 32'($signed(hz6_reg) >>> 11) + 32'd32768;
            lo6_7_reg <= $signed({1'b0, sq6_reg[31:0]}) * $signed(p6);
            hi6_7_reg <= sq6_reg[63:32] * {{16{p6[15]}}, p6};
            lo3_7_reg <= $signed({1'b0, sq6_reg[31:0]}) * $signed(p3);
            hi3_7_reg <= sq6_reg[63:32] * {{16{p3[15]}}, p3};
            v1p5_7_reg <= v1p5_6_reg;
            v1p2_7_reg <= v1p2_6_reg;
            adcp7_reg <= adcp6_reg;

            temp8_reg <= temp7_reg;
            x8_reg <= x7_reg;
            yz8_reg <= y7_reg * z7_reg;
            v2_8_reg <= {{15{lo6_7_reg[48]}}, lo6_7_reg} + {hi6_7_reg, 32'b0}
                        + ({{14{v1p5_7_reg[49]}}, v1p5_7_reg} << 17)
                        + ({{48{p4[15]}}, p4} << 35);
            v1a8_reg <= {{15{lo3_7_reg[48]}}, lo3_7_reg} + {hi3_7_reg, 32'b0};
            v1p2_8_reg <= v1p2_7_reg;
            adcp8_reg <= adcp7_reg;

            temp9_reg <= temp8_reg;
            x9_reg <= x8_reg;
            wh9_reg <= (32'($signed(yz8_reg) >>> 10) + ESC_W_OFS) * {{16{h2[15]}}, h2};
            u9_reg <= 64'($signed(v1a8_reg) >>> 8)
                      + ({{14{v1p2_8_reg[49]}}, v1p2_8_reg} << 12) + ESC_U_OFS;
            pn9_reg <= {12'b0, pb9, 31'b0} - v2_8_reg;

            temp10_reg <= temp9_reg;
            x10_reg <= x9_reg;
            w10_reg <= 32'($signed(wh9_reg + 32'd8192) >>> 14);
            ul10_reg <= 48'(u9_reg[31:0]) * 48'(p1);
            uh10_reg <= u9_reg[63:32] * {16'b0, p1};
            nl10_reg <= 44'(pn9_reg[31:0]) * 44'(ESC_P_SCALE);
            nh10_reg <= pn9_reg[63:32] * ESC_P_SCALE;

            temp11_reg <= temp10_reg;
            hh11_reg <= x10_reg * w10_reg;
            dv11_reg <= u_prod11[63:33];
            num11_reg <= {20'b0, nl10_reg} + {nh10_reg, 32'b0};

            // Signed division is done on magnitudes; a zero divisor is replaced by one.
            temp12_reg <= temp11_reg;
            hh12_reg <= hh11_reg;
            qq12_reg <= q12 * q12;
            neg12_reg <= num11_reg[63] ^ dv11_reg[30];
            inv12_reg <= (dv11_reg == '0);
            mn12_reg <= num11_reg[63] ? 64'(0) - num11_reg : num11_reg;
            md12_reg <= (dv11_reg == '0) ? 31'd1
                      : (dv11_reg[30] ? 31'(0) - dv11_reg : dv11_reg);

            temp13_reg <= temp12_reg;
            hh13_reg <= hh12_reg;
            qh13_reg <= 32'($signed(qq12_reg) >>> 7) * {24'b0, h1};
            neg13_reg <= neg12_reg;
            inv13_reg <= inv12_reg;
            mn13_reg <= mn12_reg;
            md13_reg <= md12_reg;

            side14_reg.temp <= temp13_reg;
            side14_reg.hum <= hc14[28:12];
            side14_reg.inv <= inv13_reg;
            neg14_reg <= neg13_reg;
            mn14_reg <= mn13_reg;
            md14_reg <= md13_reg;
        end
    end

    // Restoring divider, DIV_BITS quotient bits per stage.
    logic [30:0] drem_reg [NDS];
    logic [63:0] dquo_reg [NDS];
    logic [30:0] dmd_reg  [NDS];
    logic        dneg_reg [NDS];
    esc_side_t   dside_reg [NDS];

    for (genvar k = 0; k < NDS; k++) begin : g_div
        logic [30:0] rem_in;
        logic [63:0] quo_in;
        logic [30:0] md_in;
        logic        neg_in;
        esc_side_t   side_in;
        logic [30:0] rem_out;
        logic [63:0] quo_out;
        logic [31:0] trial;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = mn14_reg;
            assign md_in = md14_reg;
            assign neg_in = neg14_reg;
            assign side_in = side14_reg;
        end else begin : g_next
            assign rem_in = drem_reg[k-1];
            assign quo_in = dquo_reg[k-1];
            assign md_in = dmd_reg[k-1];
            assign neg_in = dneg_reg[k-1];
            assign side_in = dside_reg[k-1];
        end

        always_comb begin
            rem_out = rem_in;
            quo_out = quo_in;
            trial = '0;
            for (int j = 0; j < DIV_BITS; j++) begin
                trial = {rem_out, quo_out[63]};
                quo_out = {quo_out[62:0], 1'b0};
                if (trial >= {1'b0, md_in}) begin
                    rem_out = 31'(trial - {1'b0, md_in});
                    quo_out[0] = 1'b1;
                end else begin
                    rem_out = trial[30:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                drem_reg[k] <= rem_out;
                dquo_reg[k] <= quo_out;
                dmd_reg[k] <= md_in;
                dneg_reg[k] <= neg_in;
                dside_reg[k] <= side_in;
            end
        end
    end

    // Pressure tail after the divider.
    esc_side_t   side_p1_reg, side_p2_reg, side_p3_reg, side_p4_reg, side_p5_reg;
    logic [63:0] p_p1_reg, p_p2_reg, p_p3_reg, p_p4_reg, p_p5_reg;
    logic [63:0] s_p2_reg, s_p3_reg;
    logic signed [48:0] s9l_p2_reg, p8l_p2_reg;
    logic [31:0] s9h_p2_reg, p8h_p2_reg;
    logic [63:0] ps9_p3_reg, pp8_p3_reg;
    logic [63:0] ll_p4_reg, v2_p4_reg, v1_p5_reg, v2_p5_reg;
    logic [31:0] lh_p4_reg, hl_p4_reg;
    esc_out_t    out_reg;

    logic [63:0] s_c, r_c;

    assign s_c = 64'($signed(p_p1_reg) >>> 13);
    assign r_c = 64'($signed(p_p5_reg + v1_p5_reg + v2_p5_reg) >>> 8)
                 + ({{48{p7[15]}}, p7} << 4);

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_p1_reg <= dside_reg[NDS-1];
            p_p1_reg <= dneg_reg[NDS-1] ? 64'(0) - dquo_reg[NDS-1] : dquo_reg[NDS-1];

            side_p2_reg <= side_p1_reg;
            p_p2_reg <= p_p1_reg;
            s_p2_reg <= s_c;
            s9l_p2_reg <= $signed({1'b0, s_c[31:0]}) * $signed(p9);
            s9h_p2_reg <= s_c[63:32] * {{16{p9[15]}}, p9};
            p8l_p2_reg <= $signed({1'b0, p_p1_reg[31:0]}) * $signed(p8);
            p8h_p2_reg <= p_p1_reg[63:32] * {{16{p8[15]}}, p8};

            side_p3_reg <= side_p2_reg;
            p_p3_reg <= p_p2_reg;
            s_p3_reg <= s_p2_reg;
            ps9_p3_reg <= {{15{s9l_p2_reg[48]}}, s9l_p2_reg} + {s9h_p2_reg, 32'b0};
            pp8_p3_reg <= {{15{p8l_p2_reg[48]}}, p8l_p2_reg} + {p8h_p2_reg, 32'b0};

            // Low 64 bits of (p9 * s) * s from three 32-bit partial products.
            side_p4_reg <= side_p3_reg;
            p_p4_reg <= p_p3_reg;
            ll_p4_reg <= 64'(ps9_p3_reg[31:0]) * 64'(s_p3_reg[31:0]);
            lh_p4_reg <= ps9_p3_reg[31:0] * s_p3_reg[63:32];
            hl_p4_reg <= ps9_p3_reg[63:32] * s_p3_reg[31:0];
            v2_p4_reg <= 64'($signed(pp8_p3_reg) >>> 19);

            side_p5_reg <= side_p4_reg;
            p_p5_reg <= p_p4_reg;
            v1_p5_reg <= 64'($signed(ll_p4_reg + {lh_p4_reg + hl_p4_reg, 32'b0}) >>> 25);
            v2_p5_reg <= v2_p4_reg;

            out_reg.temperature_centi <= side_p5_reg.temp;
            out_reg.humidity_q22_10 <= side_p5_reg.hum;
            out_reg.pressure_q24_8 <= side_p5_reg.inv ? 32'd0 : r_c[31:0];
            out_reg.pressure_invalid <= side_p5_reg.inv;
        end
    end

    assign m_data = out_reg;

    // An invalid pressure always reads zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pressure_invalid |-> m_data.pressure_q24_8 == 32'd0)
        else $error("invalid pressure result is not zero");

    // Humidity never exceeds full scale after clamping.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.humidity_q22_10 <= 17'd102400)
        else $error("humidity above full scale");

    // A result that is not taken keeps the whole pipeline frozen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
